// ===== hw/rtl/tbc_pkg.sv =====
// tbc_pkg: shared types and constants of the barycentric coverage block
// depends on nothing; used by tbc_recip_div and triangle_barycentric_coverage_top
package tbc_pkg;

    localparam int COORD_W  = 16;
    localparam int ATTR_W   = 16;
    localparam int WFRAC    = 16;
    localparam int RECIP_SH = 38;
    localparam int AREA_W   = 35;
    localparam int RECIP_W  = 40;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_V0X = 3'd0,
        CFG_V0Y = 3'd1,
        CFG_V1X = 3'd2,
        CFG_V1Y = 3'd3,
        CFG_V2X = 3'd4,
        CFG_V2Y = 3'd5
    } t_cfg_idx;

    // setup sequencer states
    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_PROD,
        DRV_SUM,
        DRV_DIV
    } t_drv_state;

    // reciprocal divider request and response
    typedef struct packed {
        logic                start;
        logic [AREA_W-1:0]   mag;
        logic                neg;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [RECIP_W-1:0]  quot;
    } t_div_rsp;

    // saturate to a signed 24-bit weight
    function automatic logic signed [23:0] sat_w(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v > 34'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -34'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // saturate to a signed attribute component
    function automatic logic signed [ATTR_W-1:0] sat_a(input logic signed [27:0] v);
        logic signed [ATTR_W-1:0] r;
        if (v > 28'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -28'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[ATTR_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tbc_recip_div.sv =====
// tbc_recip_div: restoring divider, round(2^38 / mag) with the sign applied
// depends on tbc_pkg; one quotient bit per cycle, mag must be nonzero
module tbc_recip_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbc_pkg::t_div_req i_req,
    output tbc_pkg::t_div_rsp o_rsp
);
    localparam int STEPS = tbc_pkg::RECIP_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tbc_pkg::AREA_W-1:0]    r_rem;
    logic [tbc_pkg::RECIP_W-1:0]   r_num;
    logic [tbc_pkg::RECIP_W-1:0]   r_quo;
    logic [tbc_pkg::AREA_W-1:0]    r_mag;
    logic                          r_neg;

    logic [tbc_pkg::AREA_W:0]      rem_sh;
    logic                          fits;
    logic [tbc_pkg::AREA_W:0]      rem_sub;

    // trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_num[tbc_pkg::RECIP_W-1]};
        fits    = rem_sh >= {1'b0, r_mag};
        rem_sub = rem_sh - {1'b0, r_mag};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath, numerator carries the half-divisor rounding term
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= (tbc_pkg::RECIP_W'(1) << tbc_pkg::RECIP_SH)
                     + tbc_pkg::RECIP_W'(i_req.mag >> 1);
            r_rem <= '0;
            r_quo <= '0;
            r_mag <= i_req.mag;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_num <= {r_num[tbc_pkg::RECIP_W-2:0], 1'b0};
            r_rem <= fits ? rem_sub[tbc_pkg::AREA_W-1:0] : rem_sh[tbc_pkg::AREA_W-1:0];
            r_quo <= {r_quo[tbc_pkg::RECIP_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== hw/rtl/triangle_barycentric_coverage_top.sv =====
// triangle_barycentric_coverage_top: point-in-triangle test, weights and attribute mix
// depends on tbc_pkg and tbc_recip_div
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata 208b, tuser action
// m_axis    out  m_axis_tvalid/tready       tdata 160b
// cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_data
//
// eight register stages; one transaction per cycle while m_axis_tready is high and no setup pass runs
// a vertex write runs a setup pass (products, sum,
// 40-step reciprocal divider, result load), ending after the sum for a zero area;
// s_axis_tready is low during it, a write during the pass restarts it
// reset clears the vertices and derived coefficients, no clearing pass
// each stage holds while the one after it is full and stalled, bubbles collapse
module triangle_barycentric_coverage_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // px, py, qx, qy, attr_first, attr_second, attr_third
    input  logic [207:0] s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // inside, count, w0, w1, w2, mixed_attr, area_value, degenerate, pad
    output logic [159:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);
    localparam int NS = 8;

    // ---------------- setup ----------------
    tbc_pkg::t_drv_state r_state, n_state;
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [16:0] r_ca, r_cb, r_cd, r_ce;
    logic signed [31:0] r_p02, r_p20, r_p01, r_p10, r_p12, r_p21;
    logic signed [32:0] r_cc, r_cf;
    logic signed [34:0] r_area;
    logic signed [39:0] r_recip;
    logic signed [32:0] c_cc, c_cf;
    logic signed [34:0] c_area;
    tbc_pkg::t_div_req  div_req;
    tbc_pkg::t_div_rsp  div_rsp;
    logic               cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_addr <= 3'(tbc_pkg::CFG_V2Y));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbc_pkg::DRV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, a vertex write always restarts the pass
    always_comb begin
        n_state = r_state;
        if (cfg_hit) begin
            n_state = tbc_pkg::DRV_PROD;
        end else begin
            unique case (r_state)
                tbc_pkg::DRV_IDLE: n_state = tbc_pkg::DRV_IDLE;
                tbc_pkg::DRV_PROD: n_state = tbc_pkg::DRV_SUM;
                tbc_pkg::DRV_SUM:  n_state = (c_area == '0) ? tbc_pkg::DRV_IDLE : tbc_pkg::DRV_DIV;
                tbc_pkg::DRV_DIV:  if (div_rsp.done) n_state = tbc_pkg::DRV_IDLE;
                default:           n_state = tbc_pkg::DRV_IDLE;
            endcase
        end
    end

    // edge constants and doubled area
    always_comb begin
        c_cc   = 33'(r_p20) - 33'(r_p02);
        c_cf   = 33'(r_p01) - 33'(r_p10);
        c_area = 35'(c_cc) + 35'(c_cf) + 35'(33'(r_p12) - 33'(r_p21));
    end

    assign div_req.start = (r_state == tbc_pkg::DRV_SUM) && (c_area != '0);
    assign div_req.mag   = c_area[34] ? 35'(-c_area) : 35'(c_area);
    assign div_req.neg   = c_area[34];

    tbc_recip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // vertex registers and derived state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0; r_y0 <= '0; r_x1 <= '0; r_y1 <= '0; r_x2 <= '0; r_y2 <= '0;
            r_ca <= '0; r_cb <= '0; r_cd <= '0; r_ce <= '0;
            r_p02 <= '0; r_p20 <= '0; r_p01 <= '0; r_p10 <= '0; r_p12 <= '0; r_p21 <= '0;
            r_cc <= '0; r_cf <= '0; r_area <= '0; r_recip <= '0;
        end else begin
            if (i_cfg_we) begin
                case (tbc_pkg::t_cfg_idx'(i_cfg_addr))
                    tbc_pkg::CFG_V0X: r_x0 <= i_cfg_data;
                    tbc_pkg::CFG_V0Y: r_y0 <= i_cfg_data;
                    tbc_pkg::CFG_V1X: r_x1 <= i_cfg_data;
                    tbc_pkg::CFG_V1Y: r_y1 <= i_cfg_data;
                    tbc_pkg::CFG_V2X: r_x2 <= i_cfg_data;
                    tbc_pkg::CFG_V2Y: r_y2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == tbc_pkg::DRV_PROD) begin
                r_ca  <= 17'(r_y2) - 17'(r_y0);
                r_cb  <= 17'(r_x0) - 17'(r_x2);
                r_cd  <= 17'(r_y0) - 17'(r_y1);
                r_ce  <= 17'(r_x1) - 17'(r_x0);
                r_p02 <= r_x0 * r_y2;
                r_p20 <= r_y0 * r_x2;
                r_p01 <= r_x0 * r_y1;
                r_p10 <= r_y0 * r_x1;
                r_p12 <= r_x1 * r_y2;
                r_p21 <= r_x2 * r_y1;
            end
            if (r_state == tbc_pkg::DRV_SUM) begin
                r_cc   <= c_cc;
                r_cf   <= c_cf;
                r_area <= c_area;
                if (c_area == '0) r_recip <= '0;
            end
            if (r_state == tbc_pkg::DRV_DIV && div_rsp.done) begin
                r_recip <= div_rsp.quot;
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS:1]   r_vld;
    logic [NS+1:1] rdy;
    logic          s_acc;

    always_comb begin
        rdy[NS+1] = m_axis_tready;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[1] && (r_state == tbc_pkg::DRV_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= s_acc;
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- stage 1: edge products ----------------
    logic signed [15:0] in_px, in_py, in_qx, in_qy;
    assign in_px = s_axis_tdata[15:0];
    assign in_py = s_axis_tdata[31:16];
    assign in_qx = s_axis_tdata[47:32];
    assign in_qy = s_axis_tdata[63:48];

    logic               r1_act;
    logic [143:0]       r1_attr;
    logic signed [32:0] r1_apx, r1_aqx, r1_bpy, r1_bqy, r1_dpx, r1_dqx, r1_epy, r1_eqy;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_act  <= s_axis_tuser;
            r1_attr <= s_axis_tdata[207:64];
            r1_apx  <= r_ca * in_px;
            r1_aqx  <= r_ca * in_qx;
            r1_bpy  <= r_cb * in_py;
            r1_bqy  <= r_cb * in_qy;
            r1_dpx  <= r_cd * in_px;
            r1_dqx  <= r_cd * in_qx;
            r1_epy  <= r_ce * in_py;
            r1_eqy  <= r_ce * in_qy;
        end
    end

    // ---------------- stage 2: numerators for the four corners ----------------
    logic               r2_act;
    logic [143:0]       r2_attr;
    logic signed [34:0] r2_n1 [4];
    logic signed [34:0] r2_n2 [4];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_act   <= r1_act;
            r2_attr  <= r1_attr;
            r2_n1[0] <= 35'(r1_apx) + 35'(r1_bpy) + 35'(r_cc);
            r2_n1[1] <= 35'(r1_aqx) + 35'(r1_bpy) + 35'(r_cc);
            r2_n1[2] <= 35'(r1_aqx) + 35'(r1_bqy) + 35'(r_cc);
            r2_n1[3] <= 35'(r1_apx) + 35'(r1_bqy) + 35'(r_cc);
            r2_n2[0] <= 35'(r1_dpx) + 35'(r1_epy) + 35'(r_cf);
            r2_n2[1] <= 35'(r1_dqx) + 35'(r1_epy) + 35'(r_cf);
            r2_n2[2] <= 35'(r1_dqx) + 35'(r1_eqy) + 35'(r_cf);
            r2_n2[3] <= 35'(r1_dpx) + 35'(r1_eqy) + 35'(r_cf);
        end
    end

    // ---------------- stage 3: inside tests and magnitudes ----------------
    logic [3:0] c3_in;
    logic [2:0] c3_cnt;

    always_comb begin
        logic signed [35:0] sum;
        c3_cnt = '0;
        for (int k = 0; k < 4; k++) begin
            sum = 36'(r2_n1[k]) + 36'(r2_n2[k]);
            if (r_area == '0) begin
                c3_in[k] = 1'b1;
            end else if (!r_area[34]) begin
                c3_in[k] = !r2_n1[k][34] && !r2_n2[k][34] && (sum <= 36'(r_area));
            end else begin
                c3_in[k] = (r2_n1[k] <= 0) && (r2_n2[k] <= 0) && (sum >= 36'(r_area));
            end
            c3_cnt = c3_cnt + 3'(c3_in[k]);
        end
    end

    logic         r3_act, r3_inside, r3_neg1, r3_neg2;
    logic [2:0]   r3_cnt;
    logic [143:0] r3_attr;
    logic [34:0]  r3_u1, r3_u2;
    logic [39:0]  r3_ur;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_act    <= r2_act;
            r3_attr   <= r2_attr;
            r3_inside <= r2_act ? 1'b0 : c3_in[0];
            r3_cnt    <= r2_act ? c3_cnt : 3'd0;
            r3_u1     <= r2_n1[0][34] ? 35'(-r2_n1[0]) : 35'(r2_n1[0]);
            r3_u2     <= r2_n2[0][34] ? 35'(-r2_n2[0]) : 35'(r2_n2[0]);
            r3_ur     <= r_recip[39] ? 40'(-r_recip) : 40'(r_recip);
            r3_neg1   <= r2_n1[0][34] ^ r_recip[39];
            r3_neg2   <= r2_n2[0][34] ^ r_recip[39];
        end
    end

    // ---------------- stage 4: partial products of numerator times reciprocal ----------------
    logic         r4_act, r4_inside, r4_neg1, r4_neg2;
    logic [2:0]   r4_cnt;
    logic [143:0] r4_attr;
    logic [37:0]  r4_ll [2];
    logic [37:0]  r4_lh [2];
    logic [36:0]  r4_hl [2];
    logic [36:0]  r4_hh [2];

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_act    <= r3_act;
            r4_inside <= r3_inside;
            r4_cnt    <= r3_cnt;
            r4_attr   <= r3_attr;
            r4_neg1   <= r3_neg1;
            r4_neg2   <= r3_neg2;
            r4_ll[0]  <= r3_u1[17:0] * r3_ur[19:0];
            r4_lh[0]  <= r3_u1[17:0] * r3_ur[39:20];
            r4_hl[0]  <= r3_u1[34:18] * r3_ur[19:0];
            r4_hh[0]  <= r3_u1[34:18] * r3_ur[39:20];
            r4_ll[1]  <= r3_u2[17:0] * r3_ur[19:0];
            r4_lh[1]  <= r3_u2[17:0] * r3_ur[39:20];
            r4_hl[1]  <= r3_u2[34:18] * r3_ur[19:0];
            r4_hh[1]  <= r3_u2[34:18] * r3_ur[39:20];
        end
    end

    // ---------------- stage 5: full products ----------------
    logic         r5_act, r5_inside, r5_neg1, r5_neg2;
    logic [2:0]   r5_cnt;
    logic [143:0] r5_attr;
    logic [74:0]  r5_p [2];

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_act    <= r4_act;
            r5_inside <= r4_inside;
            r5_cnt    <= r4_cnt;
            r5_attr   <= r4_attr;
            r5_neg1   <= r4_neg1;
            r5_neg2   <= r4_neg2;
            for (int j = 0; j < 2; j++) begin
                r5_p[j] <= 75'(r4_ll[j]) + (75'(r4_lh[j]) << 20)
                         + (75'(r4_hl[j]) << 18) + (75'(r4_hh[j]) << 38);
            end
        end
    end

    // ---------------- stage 6: rounding, clamp and weights ----------------
    logic signed [31:0] c6_s [2];
    logic signed [33:0] c6_w0;

    always_comb begin
        logic [52:0] rnd;
        logic [30:0] m;
        for (int j = 0; j < 2; j++) begin
            rnd = 53'(r5_p[j][51:0]) + (53'(1) << 21);
            m   = (r5_p[j][74:52] != '0) ? (31'(1) << 30) : rnd[52:22];
            c6_s[j] = ((j == 0) ? r5_neg1 : r5_neg2) ? -$signed(32'(m)) : $signed(32'(m));
        end
        c6_w0 = (34'sd1 <<< tbc_pkg::WFRAC) - 34'(c6_s[0]) - 34'(c6_s[1]);
    end

    logic               r6_inside;
    logic [2:0]         r6_cnt;
    logic [143:0]       r6_attr;
    logic signed [23:0] r6_w [3];

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r6_inside <= r5_inside;
            r6_cnt    <= r5_cnt;
            r6_attr   <= r5_attr;
            r6_w[0]   <= r5_act ? '0 : tbc_pkg::sat_w(c6_w0);
            r6_w[1]   <= r5_act ? '0 : tbc_pkg::sat_w(34'(c6_s[0]));
            r6_w[2]   <= r5_act ? '0 : tbc_pkg::sat_w(34'(c6_s[1]));
        end
    end

    // ---------------- stage 7: attribute products ----------------
    logic               r7_inside;
    logic [2:0]         r7_cnt;
    logic signed [23:0] r7_w [3];
    logic signed [39:0] r7_pr [3][3];

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_inside <= r6_inside;
            r7_cnt    <= r6_cnt;
            r7_w      <= r6_w;
            for (int c = 0; c < 3; c++) begin
                for (int v = 0; v < 3; v++) begin
                    r7_pr[c][v] <= $signed(r6_attr[48*v + 16*c +: 16]) * r6_w[v];
                end
            end
        end
    end

    // ---------------- stage 8: mix, round and output register ----------------
    logic [47:0] c8_mix;

    always_comb begin
        logic signed [41:0] sum;
        logic [41:0]        mag;
        logic [42:0]        rnd;
        logic signed [27:0] r;
        for (int c = 0; c < 3; c++) begin
            sum = 42'(r7_pr[c][0]) + 42'(r7_pr[c][1]) + 42'(r7_pr[c][2]);
            mag = sum[41] ? 42'(-sum) : 42'(sum);
            rnd = 43'(mag) + (43'(1) << (tbc_pkg::WFRAC - 1));
            r   = sum[41] ? -$signed(28'(rnd[42:16])) : $signed(28'(rnd[42:16]));
            c8_mix[16*c +: 16] = tbc_pkg::sat_a(r);
        end
    end

    logic               r8_inside;
    logic [2:0]         r8_cnt;
    logic signed [23:0] r8_w [3];
    logic [47:0]        r8_mix;

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r8_inside <= r7_inside;
            r8_cnt    <= r7_cnt;
            r8_w      <= r7_w;
            r8_mix    <= c8_mix;
        end
    end

    assign m_axis_tvalid = r_vld[NS];
    assign m_axis_tdata  = {1'b0, (r_area == '0), r_area[33:0], r8_mix,
                            r8_w[2], r8_w[1], r8_w[0], r8_cnt, r8_inside};

    // ---------------- assertions ----------------
    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tbc_pkg::DRV_IDLE) |-> !s_axis_tready)
        else $error("transaction accepted during setup pass");

    a_zero_area_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbc_pkg::DRV_IDLE && r_area == '0) |-> (r_recip == '0))
        else $error("zero area with nonzero reciprocal");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= 3'd4))
        else $error("corner count above four");

    a_cfg_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_hit && r_state == tbc_pkg::DRV_IDLE) |=> (r_state == tbc_pkg::DRV_PROD))
        else $error("vertex write did not start setup");

endmodule
